// ===== src/ipava_pkg.sv =====
// shared types and codes for the isotonic regression block
// no dependencies; imported by every other file of the block
package ipava_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned IndexWidth  = 10;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_LEVEL = 2'd1,
    SRC_RDATA = 2'd2
  } out_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PDIV,
    S_FETCH,
    S_TEST,
    S_SWEEP,
    S_RDATA,
    S_RESP
  } state_t;

  typedef struct packed {
    logic     load;
    logic     push_init;
    logic     take_lvl;
    logic     fetch;
    logic     pool;
    logic     sweep;
    logic     commit;
    logic     clear;
    logic     rd_issue;
    logic     out_ld;
    out_src_t out_src;
    status_t  out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic j_zero;
    logic viol;
    logic j_at_i;
    logic full;
    logic idx_ok;
    op_t  op;
  } ctrl_stat_t;

endpackage

// ===== src/ipava_div.sv =====
// iterative restoring divider, signed dividend by positive divisor, one bit a cycle
// uses ipava_pkg for the quotient width
module ipava_div
  import ipava_pkg::*;
#(
  parameter int unsigned NW = 43,
  parameter int unsigned DW = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [NW-1:0]         num,
  input  logic        [DW-1:0]         den,
  output logic                         done,
  output logic signed [ValueWidth-1:0] quo
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]     rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic            neg_r, neg_nxt;
  logic [DW:0]     rem_sh;
  logic            fits;
  logic [ValueWidth-1:0] mag;

  assign rem_sh = {rem_r[DW-1:0], q_r[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(NW);
      rem_nxt  = '0;
      q_nxt    = num[NW-1] ? NW'(-num) : num;
      den_nxt  = den;
      neg_nxt  = num[NW-1];
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
      q_nxt   = {q_r[NW-2:0], fits};
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // mean of samples always fits the value width, so the low bits carry it
  assign mag  = q_r[ValueWidth-1:0];
  assign quo  = neg_r ? -mag : mag;
  assign done = done_r;

endmodule

// ===== src/ipava_dp.sv =====
// datapath: prefix and level memories, pooling registers, divider, result register
// depends on ipava_pkg and ipava_div
module ipava_dp
  import ipava_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctrl_cmd_t                    cmd,
  output ctrl_stat_t                   stat,
  input  logic [1:0]                   in_op,
  input  logic signed [ValueWidth-1:0] in_value,
  input  logic [WeightWidth-1:0]       in_weight,
  input  logic [IndexWidth-1:0]        in_index,
  output logic signed [ValueWidth-1:0] res_value,
  output logic [1:0]                   res_status
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned WW = WeightWidth + AW;
  localparam int unsigned VW = ValueWidth + AW + 1;
  localparam int unsigned XW = (CW > IndexWidth) ? CW : IndexWidth;

  logic signed [VW-1:0] vp_mem [MAX_SAMPLES];
  logic [WW-1:0]        wp_mem [MAX_SAMPLES];
  logic signed [ValueWidth-1:0] fl_mem [MAX_SAMPLES];

  op_t                   op_r;
  logic signed [ValueWidth-1:0] val_r;
  logic [WeightWidth-1:0] wt_r;
  logic [IndexWidth-1:0] idx_r;
  logic [CW-1:0]         count_r;
  logic signed [VW-1:0]  last_vp_r, vpi_r, vp_q;
  logic [WW-1:0]         last_wp_r, wpi_r, wp_q;
  logic [AW-1:0]         j_r;
  logic signed [ValueWidth-1:0] lvl_r, fl_q, res_val_r;
  logic [1:0]            res_st_r;

  logic [AW-1:0]         i_idx, jm1, jm2, rd_addr, fl_addr;
  logic [XW-1:0]         idx_ext;
  logic                  j_ge2;
  logic signed [VW-1:0]  vp_new, div_num;
  logic [WW-1:0]         wp_new, div_den;
  logic                  div_start, div_done;
  logic signed [ValueWidth-1:0] div_q;

  assign i_idx   = count_r[AW-1:0];
  assign jm1     = j_r - AW'(1);
  assign jm2     = j_r - AW'(2);
  assign j_ge2   = jm1 != '0;
  assign idx_ext = XW'(idx_r);
  assign rd_addr = idx_ext[AW-1:0];
  assign fl_addr = cmd.fetch ? jm1 : rd_addr;
  assign vp_new  = last_vp_r + {{(VW-ValueWidth){val_r[ValueWidth-1]}}, val_r};
  assign wp_new  = last_wp_r + WW'(wt_r);

  assign div_start = cmd.push_init | cmd.pool;
  always_comb begin
    if (cmd.push_init) begin
      div_num = {{(VW-ValueWidth){val_r[ValueWidth-1]}}, val_r};
      div_den = WW'(wt_r);
    end else begin
      div_num = vpi_r - (j_ge2 ? vp_q : '0);
      div_den = wpi_r - (j_ge2 ? wp_q : '0);
    end
  end

  ipava_div #(.NW(VW), .DW(WW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.push_init) begin
      vp_mem[i_idx] <= vp_new;
      wp_mem[i_idx] <= wp_new;
    end
    if (cmd.sweep) fl_mem[j_r] <= lvl_r;
    if (cmd.fetch || cmd.rd_issue) fl_q <= fl_mem[fl_addr];
    if (cmd.fetch) begin
      vp_q <= vp_mem[jm2];
      wp_q <= wp_mem[jm2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      last_vp_r <= '0;
      last_wp_r <= '0;
    end else if (cmd.clear) begin
      count_r   <= '0;
      last_vp_r <= '0;
      last_wp_r <= '0;
    end else if (cmd.commit) begin
      count_r   <= count_r + CW'(1);
      last_vp_r <= vpi_r;
      last_wp_r <= wpi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      val_r <= in_value;
      wt_r  <= (in_weight == '0) ? WeightWidth'(1) : in_weight;
      idx_r <= in_index;
    end
    if (cmd.push_init) begin
      vpi_r <= vp_new;
      wpi_r <= wp_new;
      j_r   <= i_idx;
    end else if (cmd.pool) begin
      j_r <= jm1;
    end else if (cmd.sweep) begin
      j_r <= j_r + AW'(1);
    end
    if (cmd.take_lvl) lvl_r <= div_q;
    if (cmd.out_ld) begin
      res_st_r <= cmd.out_status;
      case (cmd.out_src)
        SRC_LEVEL: res_val_r <= lvl_r;
        SRC_RDATA: res_val_r <= fl_q;
        default:   res_val_r <= '0;
      endcase
    end
  end

  assign stat.div_done = div_done;
  assign stat.j_zero   = j_r == '0;
  assign stat.viol     = fl_q > lvl_r;
  assign stat.j_at_i   = j_r == i_idx;
  assign stat.full     = count_r == CW'(MAX_SAMPLES);
  assign stat.idx_ok   = idx_ext < XW'(count_r);
  assign stat.op       = op_r;

  assign res_value  = res_val_r;
  assign res_status = res_st_r;

endmodule

// ===== src/ipava_ctrl.sv =====
// controller state machine: sequences push, pooling, sweep, read and clear
// depends on ipava_pkg
module ipava_ctrl
  import ipava_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_fire,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       in_ready,
  output logic       out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (stat.op)
          CMD_PUSH: state_nxt = stat.full ? S_RESP : S_PDIV;
          CMD_READ: state_nxt = stat.idx_ok ? S_RDATA : S_RESP;
          default:  state_nxt = S_RESP;
        endcase
      end
      S_PDIV:   if (stat.div_done) state_nxt = stat.j_zero ? S_SWEEP : S_FETCH;
      S_FETCH:  state_nxt = S_TEST;
      S_TEST:   state_nxt = stat.viol ? S_PDIV : S_SWEEP;
      S_SWEEP:  if (stat.j_at_i) state_nxt = S_RESP;
      S_RDATA:  state_nxt = S_RESP;
      S_RESP:   if (out_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_src    = SRC_ZERO;
    cmd.out_status = ST_OK;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      S_DECODE: begin
        unique case (stat.op)
          CMD_PUSH: begin
            if (stat.full) begin
              cmd.out_ld     = 1'b1;
              cmd.out_status = ST_FULL;
            end else begin
              cmd.push_init = 1'b1;
            end
          end
          CMD_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_issue = 1'b1;
            end else begin
              cmd.out_ld     = 1'b1;
              cmd.out_status = ST_RANGE;
            end
          end
          CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.out_ld = 1'b1;
          end
          default: cmd.out_ld = 1'b1;
        endcase
      end
      S_PDIV:  cmd.take_lvl = stat.div_done;
      S_FETCH: cmd.fetch = 1'b1;
      S_TEST:  cmd.pool = stat.viol;
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.j_at_i) begin
          cmd.commit  = 1'b1;
          cmd.out_ld  = 1'b1;
          cmd.out_src = SRC_LEVEL;
        end
      end
      S_RDATA: begin
        cmd.out_ld  = 1'b1;
        cmd.out_src = SRC_RDATA;
      end
      S_RESP:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/isotonic_regression_pava.sv =====
// top level of the streaming isotonic regression (pool adjacent violators) block
// depends on ipava_pkg, ipava_ctrl, ipava_dp (and ipava_div below it)
//
// One word in, one word out. A push appends a sample, computes its level as
// value/weight (truncated toward zero, zero weight taken as one) and pools back
// while the previous fitted level is larger; the fitted levels of the merged run
// are then rewritten and the newest level is returned. A read returns the stored
// level at an index, a clear empties the set. Words are taken one at a time:
// a new word is accepted only once the previous result has been taken. A push
// into a set that is not full runs one division, then for each pooling step a
// fetch, a compare and one division, then rewrites the merged run, one level
// memory write a cycle. A read fetches the stored level before its result is
// loaded. A result is held until out_tready takes it.
// No clearing pass after reset.
module isotonic_regression_pava
  import ipava_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_value[31:0], sample_weight[47:32], read_index[57:48]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // fit_value[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_fire, out_fire;
  logic signed [ValueWidth-1:0] res_value;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  // sequencing of each word
  ipava_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  // memories, pooling arithmetic and the result register
  ipava_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_value   (in_tdata[31:0]),
    .in_weight  (in_tdata[47:32]),
    .in_index   (in_tdata[57:48]),
    .res_value  (res_value),
    .res_status (out_tuser)
  );

  assign out_tdata = res_value;

endmodule

// ===== src/ipava_chk.sv =====
// port-level checker for the isotonic regression block, with its bind
// depends on ipava_pkg for the status codes and on the top level's ports
module ipava_chk
  import ipava_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // one word in flight: taking a word closes the input side
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // only defined status codes, and non-ok results carry a zero level
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |->
      (out_tuser == ST_FULL || out_tuser == ST_RANGE) && out_tdata == 32'd0)
    else $error("bad status word");

endmodule

bind isotonic_regression_pava ipava_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/tb_isotonic_regression_pava.sv =====
// self-checking testbench for the streaming isotonic regression (pava) block
// depends on ipava_pkg and isotonic_regression_pava; needs no files or arguments
`timescale 1ns / 1ps

module tb_isotonic_regression_pava;
  import ipava_pkg::*;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned RandItems  = 650;

  typedef struct {
    op_t         op;
    logic [31:0] val;
    logic [15:0] wt;
    logic [9:0]  idx;
    bit          typed;
    logic [31:0] fit;
    status_t     st;
  } word_t;

  typedef struct {
    logic [31:0] fit;
    status_t     st;
  } level_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // shadow copy of the sample set
  longint      cum_weight [Depth];
  longint      cum_value  [Depth];
  logic [31:0] fit_mem    [Depth];
  int unsigned n_samples;

  level_t      pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned hold = 0;

  always #4 clk = ~clk;

  isotonic_regression_pava u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic longint run_mean(int unsigned lo, int unsigned hi);
    longint vs, ws;
    vs = cum_value[hi];
    ws = cum_weight[hi];
    if (lo > 0) begin
      vs -= cum_value[lo - 1];
      ws -= cum_weight[lo - 1];
    end
    if (ws <= 0) return 0;
    return vs / ws; // truncates toward zero
  endfunction

  // work out the result word of one accepted input word
  function automatic level_t fit_word(word_t w);
    level_t      r;
    int unsigned i, j;
    longint      wv, lvl;
    r.fit = '0;
    r.st  = ST_OK;
    case (w.op)
      CMD_PUSH: begin
        i = n_samples;
        if (i >= Depth) begin
          r.st = ST_FULL;
        end else begin
          wv = (w.wt == 0) ? 1 : longint'(w.wt);
          cum_weight[i] = (i > 0 ? cum_weight[i - 1] : 0) + wv;
          cum_value[i]  = (i > 0 ? cum_value[i - 1] : 0) + longint'(signed'(w.val));
          lvl = run_mean(i, i);
          j = i;
          // pool back while the earlier level is larger
          while (j > 0 && longint'(signed'(fit_mem[j - 1])) > lvl) begin
            j--;
            lvl = run_mean(j, i);
            for (int unsigned k = j; k < i; k++) fit_mem[k] = lvl[31:0];
          end
          fit_mem[i] = lvl[31:0];
          n_samples = i + 1;
          r.fit = lvl[31:0];
        end
      end
      CMD_READ: begin
        if (w.idx >= n_samples) r.st = ST_RANGE;
        else r.fit = fit_mem[w.idx];
      end
      CMD_CLEAR: n_samples = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one word, wait for its handshake, then idle for a random gap, often none
  task automatic send_word(word_t w);
    level_t      e;
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, w.idx, w.wt, w.val};
    in_tuser  <= w.op;
    do @(posedge clk); while (!in_tready);
    e = fit_word(w);
    if (w.typed) begin
      e.fit = w.fit;
      e.st  = w.st;
    end
    pending_q.push_back(e);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic word_t mk(op_t op, logic [31:0] val, logic [15:0] wt, logic [9:0] idx);
    word_t w;
    w.op = op; w.val = val; w.wt = wt; w.idx = idx;
    w.typed = 0; w.fit = '0; w.st = ST_OK;
    return w;
  endfunction

  function automatic word_t mk_typed(op_t op, logic [31:0] val, logic [9:0] idx,
                                     logic [31:0] fit, status_t st);
    word_t w;
    w = mk(op, val, 16'd1, idx);
    w.typed = 1; w.fit = fit; w.st = st;
    return w;
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 9) return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
    return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
  endfunction

  function automatic logic [15:0] rand_weight();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hffff;
    if (r < 12) return 16'($urandom_range(1, 4));
    return 16'($urandom_range(1, 65535));
  endfunction

  // result side: random back-pressure, now and then a long stall, and comparison
  // against the oldest expectation
  always @(posedge clk) begin
    level_t e;
    int unsigned r;
    cycles <= cycles + 1;
    r = $urandom_range(0, 99);
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else if (r < 2) begin
      hold = $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else begin
      out_tready <= (r < 70) || (r >= 97);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word, actual fit %h status %0d", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata !== e.fit) begin
          $display("%0t: fit_value expected %h actual %h", $time, e.fit, out_tdata);
          errors++;
        end
        if (out_tuser !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_tuser);
          errors++;
        end
      end
    end
  end

  // generous stop in case the block hangs
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    word_t       table_q[$];
    word_t       w;
    int unsigned len, base;
    bit          filled;
    n_samples = 0;
    filled = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: extremes, every command and the special cases
    table_q.push_back(mk_typed(CMD_READ, '0, 10'd0, '0, ST_RANGE));     // empty after reset
    table_q.push_back(mk_typed(CMD_PUSH, 32'h7fffffff, 10'd0, 32'h7fffffff, ST_OK));
    table_q.push_back(mk(CMD_PUSH, 32'h80000000, 16'd1, 10'd0));         // pools both
    table_q.push_back(mk(CMD_READ, '0, 16'd0, 10'd0));
    table_q.push_back(mk(CMD_READ, '0, 16'd0, 10'd1));
    table_q.push_back(mk_typed(CMD_READ, '0, 10'd2, '0, ST_RANGE));
    table_q.push_back(mk(CMD_PUSH, 32'h00050000, 16'd0, 10'd0));         // zero weight
    table_q.push_back(mk(CMD_PUSH, 32'hffffffff, 16'hffff, 10'd0));
    table_q.push_back(mk(CMD_PUSH, 32'h55555555, 16'h5555, 10'h2aa));
    table_q.push_back(mk(CMD_PUSH, 32'haaaaaaaa, 16'haaaa, 10'h155));
    table_q.push_back(mk_typed(CMD_NOP, 32'hffffffff, 10'h3ff, '0, ST_OK));
    table_q.push_back(mk_typed(CMD_READ, '0, 10'h3ff, '0, ST_RANGE));
    table_q.push_back(mk(CMD_READ, '0, 16'd0, 10'd4));
    table_q.push_back(mk_typed(CMD_CLEAR, 32'hffffffff, 10'h3ff, '0, ST_OK));
    table_q.push_back(mk_typed(CMD_READ, '0, 10'd0, '0, ST_RANGE));
    table_q.push_back(mk(CMD_PUSH, -32'sd100 <<< 16, 16'd3, 10'd0));
    table_q.push_back(mk(CMD_PUSH, -32'sd300 <<< 16, 16'd1, 10'd0));
    table_q.push_back(mk(CMD_PUSH, -32'sd50 <<< 16, 16'd2, 10'd0));
    table_q.push_back(mk(CMD_PUSH, -32'sd7, 16'd3, 10'd0));               // odd truncation
    table_q.push_back(mk(CMD_READ, '0, 16'd0, 10'd0));
    table_q.push_back(mk(CMD_READ, '0, 16'd0, 10'd3));
    table_q.push_back(mk_typed(CMD_CLEAR, '0, 10'd0, '0, ST_OK));
    foreach (table_q[i]) send_word(table_q[i]);

    // hold off until the block has drained
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);

    // random sets, each started by a clear
    while (sent < RandItems + table_q.size()) begin
      send_word(mk(CMD_CLEAR, $urandom(), 16'($urandom()), 10'($urandom())));
      if (!filled && sent > 300) begin
        // one full set: rising values so there is hardly any pooling
        filled = 1;
        base = $urandom_range(0, 1000);
        for (int unsigned k = 0; k < Depth; k++)
          send_word(mk(CMD_PUSH, 32'(base + k * 3) <<< 8, 16'd1, 10'($urandom())));
        for (int unsigned k = 0; k < 4; k++)
          send_word(mk(CMD_PUSH, rand_value(), rand_weight(), 10'($urandom())));
        for (int unsigned k = 0; k < 6; k++)
          send_word(mk(CMD_READ, $urandom(), 16'($urandom()), 10'($urandom())));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
        for (int unsigned k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w = mk(CMD_PUSH, rand_value(), rand_weight(), 10'($urandom()));
            6, 7: w = mk(CMD_READ, $urandom(), 16'($urandom()),
                         10'($urandom_range(0, n_samples + 1)));
            8: w = mk(CMD_READ, $urandom(), 16'($urandom()), 10'($urandom()));
            default: w = mk(CMD_NOP, $urandom(), 16'($urandom()), 10'($urandom()));
          endcase
          send_word(w);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
